[rtl/core/kpsc_pkg.sv]
// Shared package for the keyed printable substitution cipher unit.
// Holds default parameters, fixed field widths, register indexes, the
// sequencer state type and the control and status groups used between modules.
`timescale 1ns / 1ps

package kpsc_pkg;

    localparam int ALPHABET_SIZE_DEF = 95;
    localparam int FIRST_CODE_DEF    = 32;

    localparam int CHAR_W      = 8;
    localparam int KEY_W       = 32;
    localparam int DIGIT_W     = 4;
    localparam int DIGIT_STEPS = KEY_W / DIGIT_W;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_CIPHER_KEY   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECRYPT_MODE = 1'b1;

    localparam logic REQ_BUILD     = 1'b0;
    localparam logic REQ_TRANSLATE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_SWAP_WA,
        ST_SWAP_WB,
        ST_FILL_RD,
        ST_FILL_WR
    } seq_state_t;

    typedef struct packed {
        logic build_start;
        logic rd_en;
    } tbl_ctrl_t;

    typedef struct packed {
        logic idle;
        logic built;
    } tbl_status_t;

endpackage

[rtl/core/kpsc_rem_unit.sv]
// Iterative remainder unit: key mod divisor, four key bits per cycle.
// Uses kpsc_pkg for key and digit widths.
`timescale 1ns / 1ps

module kpsc_rem_unit #(
    parameter int DIV_W = $clog2(kpsc_pkg::ALPHABET_SIZE_DEF)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [kpsc_pkg::KEY_W-1:0]  dividend,
    input  logic [DIV_W-1:0]            divisor,
    output logic                        done,
    output logic [DIV_W-1:0]            remainder
);
    import kpsc_pkg::*;

    localparam int CNT_W = (DIGIT_STEPS > 1) ? $clog2(DIGIT_STEPS) : 1;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [KEY_W-1:0]   shift_reg, shift_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
    end

    always_comb begin
        logic [DIV_W:0]   t;
        logic [DIV_W-1:0] r;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        r          = rem_reg;
        t          = '0;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            div_next   = divisor;
            rem_next   = '0;
        end else if (busy_reg) begin
            // reduce one digit: shift in the top key bits, subtract when over
            for (int b = 0; b < DIGIT_W; b++) begin
                t = {r, shift_reg[KEY_W-1-b]};
                if (t >= {1'b0, div_reg}) begin
                    t = t - {1'b0, div_reg};
                end
                r = t[DIV_W-1:0];
            end
            rem_next   = r;
            shift_next = shift_reg << DIGIT_W;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIGIT_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < div_reg))
        else $error("remainder not below divisor");
    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("remainder unit still busy when done");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("remainder unit did not start");
`endif

endmodule

[rtl/core/kpsc_tables.sv]
// Forward and inverse substitution tables with the build sequencer.
// Depends on kpsc_pkg and kpsc_rem_unit; memories have synchronous, registered reads.
`timescale 1ns / 1ps

module kpsc_tables #(
    parameter int ALPHABET_SIZE = kpsc_pkg::ALPHABET_SIZE_DEF,
    parameter int AW            = $clog2(ALPHABET_SIZE)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [kpsc_pkg::KEY_W-1:0]  cipher_key,
    input  kpsc_pkg::tbl_ctrl_t         ctrl,
    input  logic [AW-1:0]               rd_addr,
    output kpsc_pkg::tbl_status_t       status,
    output logic [AW-1:0]               fwd_q,
    output logic [AW-1:0]               inv_q
);
    import kpsc_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(ALPHABET_SIZE - 1);

    logic [AW-1:0] fwd_mem [ALPHABET_SIZE];
    logic [AW-1:0] inv_mem [ALPHABET_SIZE];

    seq_state_t    state_reg, state_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] k_reg, k_next;
    logic          built_reg, built_next;
    logic [KEY_W-1:0] key_reg, key_next;

    logic          fwd_we, a_re, b_re, inv_we, inv_re;
    logic [AW-1:0] fwd_waddr, fwd_wdata, a_addr, b_addr;
    logic [AW-1:0] inv_waddr, inv_wdata, inv_raddr;
    logic [AW-1:0] a_q_reg, b_q_reg, inv_q_reg;

    logic          rem_start, rem_done;
    logic [AW-1:0] rem_value;

    kpsc_rem_unit #(
        .DIV_W (AW)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (key_reg),
        .divisor   (i_reg),
        .done      (rem_done),
        .remainder (rem_value)
    );

    // forward table: one write port, two read ports
    always_ff @(posedge aclk) begin
        if (fwd_we) begin
            fwd_mem[fwd_waddr] <= fwd_wdata;
        end
        if (a_re) begin
            a_q_reg <= fwd_mem[a_addr];
        end
        if (b_re) begin
            b_q_reg <= fwd_mem[b_addr];
        end
    end

    // inverse table: one write port, one read port
    always_ff @(posedge aclk) begin
        if (inv_we) begin
            inv_mem[inv_waddr] <= inv_wdata;
        end
        if (inv_re) begin
            inv_q_reg <= inv_mem[inv_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            built_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            built_reg <= built_next;
        end
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        key_reg <= key_next;
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        key_next   = key_reg;
        built_next = built_reg;
        fwd_we     = 1'b0;
        fwd_waddr  = k_reg;
        fwd_wdata  = k_reg;
        a_re       = 1'b0;
        a_addr     = k_reg;
        b_re       = 1'b0;
        b_addr     = rem_value;
        inv_we     = 1'b0;
        inv_waddr  = a_q_reg;
        inv_wdata  = k_reg;
        inv_re     = 1'b0;
        inv_raddr  = rd_addr;
        rem_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                a_re   = ctrl.rd_en;
                a_addr = rd_addr;
                inv_re = ctrl.rd_en;
                if (ctrl.build_start) begin
                    // hold the key for the whole build
                    key_next   = cipher_key;
                    k_next     = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                // lay down the identity order
                fwd_we = 1'b1;
                if (k_reg == LAST) begin
                    i_next     = LAST;
                    state_next = ST_MOD_GO;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_MOD_GO: begin
                rem_start  = 1'b1;
                state_next = ST_MOD_WAIT;
            end
            ST_MOD_WAIT: begin
                if (rem_done) begin
                    a_re       = 1'b1;
                    a_addr     = i_reg;
                    b_re       = 1'b1;
                    j_next     = rem_value;
                    state_next = ST_SWAP_WA;
                end
            end
            ST_SWAP_WA: begin
                fwd_we     = 1'b1;
                fwd_waddr  = i_reg;
                fwd_wdata  = b_q_reg;
                state_next = ST_SWAP_WB;
            end
            ST_SWAP_WB: begin
                fwd_we    = 1'b1;
                fwd_waddr = j_reg;
                fwd_wdata = a_q_reg;
                if (i_reg == AW'(1)) begin
                    k_next     = '0;
                    state_next = ST_FILL_RD;
                end else begin
                    i_next     = i_reg - 1'b1;
                    state_next = ST_MOD_GO;
                end
            end
            ST_FILL_RD: begin
                a_re       = 1'b1;
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                inv_we = 1'b1;
                if (k_reg == LAST) begin
                    built_next = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_FILL_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign status.idle  = (state_reg == ST_IDLE);
    assign status.built = built_reg;
    assign fwd_q        = a_q_reg;
    assign inv_q        = inv_q_reg;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_done |-> (state_reg == ST_MOD_WAIT))
        else $error("remainder finished outside wait state");
    a_swap_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWAP_WA) |-> (j_reg < i_reg))
        else $error("swap partner not below position");
    a_built_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        built_reg |=> built_reg)
        else $error("built flag dropped");
`endif

endmodule

[rtl/core/keyed_printable_substitution_cipher_unit.sv]
// Keyed printable substitution cipher unit: an accepted transfer goes through the lookup
// stage and output register to its result; translates sustain one per cycle while the
// sequencer is idle and the result side keeps up. A build occupies the table sequencer for
// the identity fill, a remainder and swap at each of ALPHABET_SIZE-1 positions and the
// inverse fill, paced by the 4-bit-per-cycle remainder unit and one forward write port.
// Reset (aresetn, synchronous, active low) clears control and config; tables stay unbuilt.
`timescale 1ns / 1ps

module keyed_printable_substitution_cipher_unit #(
    parameter int ALPHABET_SIZE = kpsc_pkg::ALPHABET_SIZE_DEF,
    parameter int FIRST_CODE    = kpsc_pkg::FIRST_CODE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [kpsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [kpsc_pkg::KEY_W-1:0]         cfg_wdata,
    // request channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [kpsc_pkg::CHAR_W-1:0]        s_tdata,   // [7:0] char_in
    input  logic                               s_tuser,   // [0] req_type
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kpsc_pkg::CHAR_W-1:0]        m_tdata,   // [7:0] char_out
    output logic                               m_tuser    // [0] mapped
);
    import kpsc_pkg::*;

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int CW = CHAR_W + 1;
    localparam logic [CW-1:0] BAND_LO = CW'(FIRST_CODE);
    localparam logic [CW-1:0] BAND_HI = CW'(FIRST_CODE + ALPHABET_SIZE);

    // configuration registers
    logic [KEY_W-1:0] cipher_key_reg;
    logic             decrypt_mode_reg;

    // lookup stage, lined up with the table read
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_hit_reg, s1_hit_next;
    logic             s1_dec_reg, s1_dec_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_data_reg, out_data_next;
    logic              out_mapped_reg, out_mapped_next;

    tbl_ctrl_t     tbl_ctrl;
    tbl_status_t   tbl_status;
    logic [AW-1:0] tbl_addr, fwd_q, inv_q;

    logic          accept, out_free, in_band;
    logic [CW-1:0] char_ext, char_off, sum;
    logic [AW-1:0] entry;

    kpsc_tables #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .AW            (AW)
    ) u_tables (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cipher_key (cipher_key_reg),
        .ctrl       (tbl_ctrl),
        .rd_addr    (tbl_addr),
        .status     (tbl_status),
        .fwd_q      (fwd_q),
        .inv_q      (inv_q)
    );

    // register writes land at once; the key is read by the build sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cipher_key_reg   <= '0;
            decrypt_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CIPHER_KEY:   cipher_key_reg   <= cfg_wdata;
                CFG_DECRYPT_MODE: decrypt_mode_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // the output register frees its slot when empty or when the transfer goes out
    assign out_free = !out_valid_reg || m_tready;
    // take a new request while the sequencer is idle and the lookup stage can drain
    assign s_tready = tbl_status.idle && (!s1_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;

    assign char_ext = {1'b0, s_tdata};
    assign char_off = char_ext - BAND_LO;
    assign in_band  = (char_ext >= BAND_LO) && (char_ext < BAND_HI);
    assign tbl_addr = char_off[AW-1:0];

    assign tbl_ctrl.rd_en       = accept && (s_tuser == REQ_TRANSLATE);
    assign tbl_ctrl.build_start = accept && (s_tuser == REQ_BUILD);

    assign entry = s1_dec_reg ? inv_q : fwd_q;
    assign sum   = BAND_LO + CW'(entry);

    always_comb begin
        s1_valid_next   = s1_valid_reg;
        s1_hit_next     = s1_hit_reg;
        s1_dec_next     = s1_dec_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_mapped_next = out_mapped_reg;
        // advance the lookup stage into the output register
        if (s1_valid_reg && out_free) begin
            out_valid_next  = 1'b1;
            out_data_next   = s1_hit_reg ? sum[CHAR_W-1:0] : '0;
            out_mapped_next = s1_hit_reg;
            s1_valid_next   = 1'b0;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        // a build request yields an unmapped zero result
        if (accept) begin
            s1_valid_next = 1'b1;
            s1_hit_next   = (s_tuser == REQ_TRANSLATE) && in_band && tbl_status.built;
            s1_dec_next   = decrypt_mode_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
        s1_hit_reg     <= s1_hit_next;
        s1_dec_reg     <= s1_dec_next;
        out_data_reg   <= out_data_next;
        out_mapped_reg <= out_mapped_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_mapped_reg;

`ifndef SYNTHESIS
    a_mapped_needs_built: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> tbl_status.built)
        else $error("mapped result before tables were built");
    a_unmapped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("unmapped result carries data");
    a_build_busies: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == REQ_BUILD)) |=> !tbl_status.idle)
        else $error("build transfer did not start the sequencer");
    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("lookup stage lost a result");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for keyed_printable_substitution_cipher_unit.
// Depends on kpsc_pkg and the unit's RTL; predicts each result from its own table model
// and checks every result transfer in order under random idling and back-pressure.
`timescale 1ns / 1ps

module tb_top;
    import kpsc_pkg::*;

    localparam int ALPHA         = ALPHABET_SIZE_DEF;
    localparam int FIRST         = FIRST_CODE_DEF;
    // Longest run of cycles with no transfer on either side. A build keeps the
    // sequencer busy and the long hold-off stalls results, both well within it.
    localparam int QUIET_LIMIT   = 20000;
    // Cycles to watch for stray results once nothing is pending.
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              mapped;
    } cipher_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [KEY_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [CHAR_W-1:0]      s_tdata;   // [7:0] char_in
    logic                   s_tuser;   // [0] req_type
    logic                   m_tvalid;
    logic                   m_tready;
    logic [CHAR_W-1:0]      m_tdata;   // [7:0] char_out
    logic                   m_tuser;   // [0] mapped

    // Table model: key and mode as last written, tables as last built.
    logic [KEY_W-1:0] key_reg;
    logic             decrypt_sel;
    logic             tables_ready;
    logic [6:0]       fwd_tab [ALPHA];
    logic [6:0]       inv_tab [ALPHA];

    cipher_result_t pending_cipher_out [$];
    int             mismatch_count;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             hold_request;

    keyed_printable_substitution_cipher_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Shuffle the identity order with the current key, then fill both tables.
    function automatic void build_cipher_tables();
        logic [6:0]  order [ALPHA];
        logic [6:0]  t;
        int unsigned j;
        for (int k = 0; k < ALPHA; k++) order[k] = 7'(k);
        for (int unsigned i = ALPHA - 1; i > 0; i--) begin
            j        = key_reg % i;
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int k = 0; k < ALPHA; k++) begin
            fwd_tab[k]        = order[k];
            inv_tab[order[k]] = 7'(k);
        end
        tables_ready = 1'b1;
    endfunction

    // Work out the result of one accepted request and queue it.
    function automatic void compute_cipher_result(input logic req, input logic [CHAR_W-1:0] ch);
        cipher_result_t r;
        int             idx;
        logic [6:0]     v;
        r   = '0;
        idx = int'(ch) - FIRST;
        if (req == REQ_BUILD) begin
            build_cipher_tables();
        end else if (tables_ready && idx >= 0 && idx < ALPHA) begin
            v          = decrypt_sel ? inv_tab[idx] : fwd_tab[idx];
            r.char_out = 8'(int'(v) + FIRST);
            r.mapped   = 1'b1;
        end
        pending_cipher_out.push_back(r);
    endfunction

    // Offer one request, idling at random first; leave tvalid high on return
    // so that a back-to-back request needs no second assignment this step.
    task automatic send_item(input logic req, input logic [CHAR_W-1:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        compute_cipher_result(req, ch);
    endtask

    // Drop tvalid and hold until every pending result has been taken.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_cipher_out.size() != 0);
    endtask

    // Write one register while the unit is idle; mirror it in the model.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [KEY_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_CIPHER_KEY)
            key_reg = val;
        else
            decrypt_sel = val[0];
        @(posedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return KEY_W'($urandom_range(200));
            default: return $urandom;
        endcase
    endfunction

    // Mostly printable bytes, the rest from the whole byte range.
    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(99) < 80)
            return CHAR_W'($urandom_range(FIRST + ALPHA - 1, FIRST));
        return CHAR_W'($urandom_range(255));
    endfunction

    // Translates before any build must come back unmapped.
    task automatic test_unbuilt_translate();
        send_item(REQ_TRANSLATE, 8'd65);
        send_item(REQ_TRANSLATE, 8'd32);
        send_item(REQ_TRANSLATE, 8'd126);
        send_item(REQ_TRANSLATE, 8'd0);
        send_item(REQ_TRANSLATE, 8'd255);
        wait_drain();
    endtask

    // Build with the extreme keys; probe the band edges and just outside them.
    task automatic test_build_extremes();
        write_reg(CFG_CIPHER_KEY, '0);
        write_reg(CFG_DECRYPT_MODE, '0);
        send_item(REQ_BUILD, 8'hFF);
        send_item(REQ_TRANSLATE, 8'd32);
        send_item(REQ_TRANSLATE, 8'd126);
        send_item(REQ_TRANSLATE, 8'd31);
        send_item(REQ_TRANSLATE, 8'd127);
        send_item(REQ_TRANSLATE, 8'h80);
        wait_drain();
        write_reg(CFG_CIPHER_KEY, '1);
        send_item(REQ_BUILD, 8'h41);
        send_item(REQ_TRANSLATE, 8'd32);
        send_item(REQ_TRANSLATE, 8'd126);
        send_item(REQ_TRANSLATE, 8'h41);
        wait_drain();
    endtask

    // Same tables read through the inverse.
    task automatic test_decrypt_mode();
        write_reg(CFG_DECRYPT_MODE, KEY_W'(1));
        send_item(REQ_TRANSLATE, 8'd32);
        send_item(REQ_TRANSLATE, 8'd126);
        send_item(REQ_TRANSLATE, 8'h7A);
        wait_drain();
        write_reg(CFG_DECRYPT_MODE, '0);
    endtask

    // A new key without a build must leave the tables as they were.
    task automatic test_key_change_holds_tables();
        write_reg(CFG_CIPHER_KEY, 32'd12345);
        send_item(REQ_TRANSLATE, 8'd32);
        send_item(REQ_TRANSLATE, 8'd126);
        send_item(REQ_TRANSLATE, 8'h6D);
        wait_drain();
    endtask

    // Rounds of: new key and mode, build, a run of translates, flip the mode,
    // another run on the same tables. A few stray builds land mid-run.
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
        int sent;
        int run_len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent          = 0;
        while (sent < n_items) begin
            wait_drain();
            write_reg(CFG_CIPHER_KEY, pick_key());
            write_reg(CFG_DECRYPT_MODE, KEY_W'($urandom_range(1)));
            send_item(REQ_BUILD, 8'($urandom));
            sent++;
            for (int pass = 0; pass < 2; pass++) begin
                if (pass == 1) begin
                    wait_drain();
                    write_reg(CFG_DECRYPT_MODE, KEY_W'(!decrypt_sel));
                end
                run_len = $urandom_range(40, 12);
                repeat (run_len) begin
                    if ($urandom_range(99) < 2)
                        send_item(REQ_BUILD, 8'($urandom));
                    else
                        send_item(REQ_TRANSLATE, pick_char());
                    sent++;
                end
            end
        end
        wait_drain();
    endtask

    // Stall the result side for a long stretch while requests keep coming,
    // so the unit fills and holds off its input; then pause until it drains.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        repeat (48) send_item(REQ_TRANSLATE, pick_char());
        wait_drain();
    endtask

    // Result side: random tready, or a counted hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare every result transfer with the oldest pending prediction.
    always @(posedge aclk) begin
        cipher_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cipher_out.size() == 0) begin
                $error("result with nothing pending: char_out %0h mapped %0b", m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_cipher_out.pop_front();
                if (m_tdata !== want.char_out) begin
                    $error("char_out: expected %0h, got %0h", want.char_out, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.mapped) begin
                    $error("mapped: expected %0b, got %0b", want.mapped, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if neither side moves a transfer for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        key_reg        = '0;
        decrypt_sel    = 1'b0;
        tables_ready   = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_request   = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unbuilt_translate();
        test_build_extremes();
        test_decrypt_mode();
        test_key_change_holds_tables();
        test_random_traffic(34, 83, 140);
        test_random_traffic(83, 34, 140);
        test_random_traffic(0, 0, 140);
        test_backpressure();

        // Nothing pending now; watch a little longer for stray results.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/kpsc_pkg.sv
rtl/core/kpsc_rem_unit.sv
rtl/core/kpsc_tables.sv
rtl/core/keyed_printable_substitution_cipher_unit.sv
tb/sv/tb_top.sv
